[sv/bsq_pkg.sv]
`timescale 1ns / 1ps

package bsq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_NUM_BANDS   = 3;

	localparam int PRIO_W = 8;
	localparam int TIME_W = 16;
	localparam int CFG_W  = 8;
	localparam int CFG_IDX_W = 2;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BAND_ZERO_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_ONE_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_TWO_LIMIT  = 2'd2;

	localparam logic [PRIO_W-1:0] RST_BAND_ZERO_LIMIT = 8'd10;
	localparam logic [PRIO_W-1:0] RST_BAND_ONE_LIMIT  = 8'd20;
	localparam logic [PRIO_W-1:0] RST_BAND_TWO_LIMIT  = 8'd30;

	typedef struct packed {
		logic              operation;
		logic [PRIO_W-1:0] priority_req;
		logic [TIME_W-1:0] task_time;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [1:0]        band;
		logic [PRIO_W-1:0] out_priority;
		logic [TIME_W-1:0] out_time;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] ctime;
	} entry_t;

	typedef struct packed {
		logic take_new;
		logic take_prev;
		logic take_next;
	} cell_ctl_t;

endpackage

[sv/banded_sorted_priority_queue.sv]
`timescale 1ns / 1ps

// Channel | Dir | Handshake              | Beat
// --------+-----+------------------------+------------------------------------------
// req     | in  | req_valid / req_stall  | operation, priority_req, task_time
// rsp     | out | rsp_valid / rsp_stall  | status, band, out_priority, out_time
// cfg     | in  | cfg_we                 | cfg_index, cfg_data (band limits)
//
// One request per cycle unless stalled. Each band is a row of cells that shifts for a
// sorted insert or a head pop; the response is in the output register the cycle after.
// req_stall is high while a response waits in the output register under rsp_stall.
// Reset clears the band counts and loads the limits 10, 20, 30; no clearing pass.

module banded_sorted_priority_queue #(
	parameter int QUEUE_DEPTH = bsq_pkg::DEF_QUEUE_DEPTH,
	parameter int NUM_BANDS   = bsq_pkg::DEF_NUM_BANDS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  bsq_pkg::req_t                       req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output bsq_pkg::rsp_t                       rsp,
	input  logic                                cfg_we,
	input  logic [bsq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bsq_pkg::CFG_W-1:0]           cfg_data
);
	import bsq_pkg::*;

	localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

	logic [PRIO_W-1:0] limit_q [3];
	logic [PRIO_W-1:0] band_limit [NUM_BANDS];
	entry_t            band_head  [NUM_BANDS];
	logic              band_empty [NUM_BANDS];
	logic              band_full  [NUM_BANDS];
	logic              band_ins   [NUM_BANDS];
	logic              band_pop   [NUM_BANDS];

	logic              accept;
	logic              found;
	logic [BAND_W-1:0] sel;
	entry_t            new_entry;
	rsp_t              result;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q[0] <= RST_BAND_ZERO_LIMIT;
			limit_q[1] <= RST_BAND_ONE_LIMIT;
			limit_q[2] <= RST_BAND_TWO_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BAND_ZERO_LIMIT: limit_q[0] <= cfg_data;
				REG_BAND_ONE_LIMIT:  limit_q[1] <= cfg_data;
				REG_BAND_TWO_LIMIT:  limit_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept    = req_valid && !req_stall;
	assign new_entry = '{prio: req.priority_req, ctime: req.task_time};

	// first band whose limit covers the priority wins
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int b = NUM_BANDS - 1; b >= 0; b--) begin
			if (req.priority_req <= band_limit[b]) begin
				found = 1'b1;
				sel   = BAND_W'(b);
			end
		end
	end

	for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
		localparam int LIM_IDX = (b < 2) ? b : 2;

		assign band_limit[b] = limit_q[LIM_IDX];
		assign band_ins[b]   = accept && found && (sel == BAND_W'(b)) &&
			(req.operation == OP_INSERT) && !band_full[b];
		assign band_pop[b]   = accept && found && (sel == BAND_W'(b)) &&
			(req.operation == OP_POP) && !band_empty[b];

		bsq_band #(
			.QUEUE_DEPTH (QUEUE_DEPTH)
		) u_band (
			.clk       (clk),
			.arst_n    (arst_n),
			.ins       (band_ins[b]),
			.pop       (band_pop[b]),
			.new_entry (new_entry),
			.head      (band_head[b]),
			.empty     (band_empty[b]),
			.full      (band_full[b])
		);
	end

	always_comb begin
		result              = '0;
		result.out_priority = (req.operation == OP_INSERT) ? req.priority_req : '0;
		if (!found) begin
			result.status = ST_RANGE;
		end else begin
			result.band = 2'(sel);
			if (req.operation == OP_POP) begin
				if (band_empty[sel]) begin
					result.status = ST_EMPTY;
				end else begin
					result.status       = ST_OK;
					result.out_priority = band_head[sel].prio;
					result.out_time     = band_head[sel].ctime;
				end
			end else if (band_full[sel]) begin
				result.status = ST_FULL;
			end else begin
				result.status = ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= result;
		end
	end

	assign req_stall = rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/bsq_cell.sv]
`timescale 1ns / 1ps

module bsq_cell (
	input  logic               clk,
	input  bsq_pkg::cell_ctl_t ctl,
	input  bsq_pkg::entry_t    new_entry,
	input  bsq_pkg::entry_t    prev_entry,
	input  bsq_pkg::entry_t    next_entry,
	output bsq_pkg::entry_t    entry,
	output logic               gt
);
	import bsq_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.take_new) begin
			entry_q <= new_entry;
		end else if (ctl.take_prev) begin
			entry_q <= prev_entry;
		end else if (ctl.take_next) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign gt    = entry_q.prio > new_entry.prio;

endmodule

[sv/bsq_band.sv]
`timescale 1ns / 1ps

module bsq_band #(
	parameter int QUEUE_DEPTH = bsq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ins,
	input  logic            pop,
	input  bsq_pkg::entry_t new_entry,
	output bsq_pkg::entry_t head,
	output logic            empty,
	output logic            full
);
	import bsq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	entry_t           cell_entry [QUEUE_DEPTH];
	logic             cell_gt    [QUEUE_DEPTH];
	logic             place      [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    prev_e;
		entry_t    next_e;

		// a cell from the insert point up to the first free cell takes part in the
		// shift; entries are sorted, so this is monotonic up to that free cell
		assign place[i] = (CNT_W'(i) < count_q) ? cell_gt[i] : (CNT_W'(i) == count_q);

		if (i == 0) begin : g_first
			assign ctl.take_new  = ins && place[i];
			assign ctl.take_prev = 1'b0;
			assign prev_e        = new_entry;
		end else begin : g_rest
			assign ctl.take_new  = ins && place[i] && !place[i-1];
			assign ctl.take_prev = ins && place[i] && place[i-1];
			assign prev_e        = cell_entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			// hold the last cell on pop
			assign ctl.take_next = 1'b0;
			assign next_e        = cell_entry[i];
		end else begin : g_mid
			assign ctl.take_next = pop;
			assign next_e        = cell_entry[i+1];
		end

		bsq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.gt         (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign head  = cell_entry[0];
	assign empty = count_q == '0;
	assign full  = count_q == CNT_W'(QUEUE_DEPTH);

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import bsq_pkg::*;

	localparam int QDEPTH = DEF_QUEUE_DEPTH;
	localparam int NBANDS = DEF_NUM_BANDS;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	banded_sorted_priority_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mirror of the band queues, kept in step with accepted beats
	entry_t            shadow_band [NBANDS][QDEPTH];
	int                shadow_count [NBANDS];
	logic [PRIO_W-1:0] shadow_limit [3];
	logic [PRIO_W-1:0] last_prio = '0;

	rsp_t        pending_rsp [$];
	int unsigned errors = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned cycle_count = 0;

	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		int   b;
		int   n;
		int   pos;
		o = '0;
		b = -1;
		for (int i = 0; i < NBANDS; i++) begin
			if (b < 0 && r.priority_req <= shadow_limit[i > 2 ? 2 : i])
				b = i;
		end
		if (r.operation == OP_INSERT)
			o.out_priority = r.priority_req;
		if (b < 0) begin
			o.status = ST_RANGE;
		end else begin
			o.band = b[1:0];
			n = shadow_count[b];
			if (r.operation == OP_POP) begin
				if (n == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.out_priority = shadow_band[b][0].prio;
					o.out_time = shadow_band[b][0].ctime;
					for (int k = 0; k < n - 1; k++)
						shadow_band[b][k] = shadow_band[b][k + 1];
					shadow_count[b] = n - 1;
				end
			end else if (n >= QDEPTH) begin
				o.status = ST_FULL;
			end else begin
				// equal priorities stay in arrival order
				pos = 0;
				while (pos < n && shadow_band[b][pos].prio <= r.priority_req)
					pos++;
				for (int k = n; k > pos; k--)
					shadow_band[b][k] = shadow_band[b][k - 1];
				shadow_band[b][pos].prio = r.priority_req;
				shadow_band[b][pos].ctime = r.task_time;
				shadow_count[b] = n + 1;
			end
		end
		return o;
	endfunction

	function automatic req_t random_request(int unsigned insert_pct);
		req_t              r;
		logic [PRIO_W-1:0] top;
		int unsigned       pick;
		top = shadow_limit[0];
		if (shadow_limit[1] > top)
			top = shadow_limit[1];
		if (shadow_limit[2] > top)
			top = shadow_limit[2];
		r.operation = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
		r.task_time = TIME_W'($urandom_range(16'hFFFF));
		pick = $urandom_range(99);
		if (pick < 60)
			r.priority_req = PRIO_W'($urandom_range(top));
		else if (pick < 75)
			r.priority_req = shadow_limit[2'($urandom_range(2))];
		else if (pick < 85)
			r.priority_req = last_prio;
		else if (pick < 93)
			r.priority_req = shadow_limit[2'($urandom_range(2))] + 8'd1;
		else
			r.priority_req = PRIO_W'($urandom_range(255));
		last_prio = r.priority_req;
		return r;
	endfunction

	// Enter and leave at a falling edge; valid stays up for a back-to-back beat
	task automatic send_req(input req_t r, input bit use_typed, input rsp_t typed);
		rsp_t want;
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		want = serve_request(r);
		if (use_typed)
			want = typed;
		pending_rsp.push_back(want);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx <= REG_BAND_TWO_LIMIT)
			shadow_limit[idx] = val;
		@(negedge clk);
	endtask

	task automatic load_limits(input logic [CFG_W-1:0] l0, l1, l2);
		drain_results();
		write_limit(REG_BAND_ZERO_LIMIT, l0);
		write_limit(REG_BAND_ONE_LIMIT, l1);
		write_limit(REG_BAND_TWO_LIMIT, l2);
		// no register behind this index; the write must leave the limits alone
		write_limit(REG_UNUSED, CFG_W'($urandom_range(255)));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned insert_pct;
		rsp_t        none;
		insert_pct = 50;
		none = '0;
		for (int unsigned i = 0; i < count; i++) begin
			// shift the insert/pop mix now and then so bands both fill and run dry
			if (i % 32 == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 20;
					1: insert_pct = 50;
					default: insert_pct = 85;
				endcase
			end
			send_req(random_request(insert_pct), 1'b0, none);
		end
	endtask

	typedef struct {
		logic              op;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] ctime;
		int                reps;
		bit                typed;
		logic [1:0]        st;
		logic [1:0]        bd;
		logic [PRIO_W-1:0] oprio;
		logic [TIME_W-1:0] otime;
	} script_row_t;

	// Limits at reset: 10, 20, 30
	script_row_t script [24] = '{
		'{OP_POP,    8'd0,   16'h0000, 1,  1'b1, ST_EMPTY, 2'd0, 8'd0,   16'h0000},
		'{OP_POP,    8'd30,  16'hFFFF, 1,  1'b1, ST_EMPTY, 2'd2, 8'd0,   16'h0000},
		'{OP_INSERT, 8'd31,  16'hFFFF, 1,  1'b1, ST_RANGE, 2'd0, 8'd31,  16'h0000},
		'{OP_POP,    8'd255, 16'h0000, 1,  1'b1, ST_RANGE, 2'd0, 8'd0,   16'h0000},
		'{OP_INSERT, 8'd255, 16'h0000, 1,  1'b1, ST_RANGE, 2'd0, 8'd255, 16'h0000},
		'{OP_INSERT, 8'd10,  16'hFFFF, 1,  1'b1, ST_OK,    2'd0, 8'd10,  16'h0000},
		'{OP_INSERT, 8'd0,   16'h1234, 1,  1'b1, ST_OK,    2'd0, 8'd0,   16'h0000},
		'{OP_INSERT, 8'd10,  16'h0001, 1,  1'b1, ST_OK,    2'd0, 8'd10,  16'h0000},
		'{OP_INSERT, 8'd11,  16'hAAAA, 1,  1'b1, ST_OK,    2'd1, 8'd11,  16'h0000},
		'{OP_INSERT, 8'd20,  16'h5555, 1,  1'b1, ST_OK,    2'd1, 8'd20,  16'h0000},
		'{OP_INSERT, 8'd30,  16'hFFFF, 1,  1'b1, ST_OK,    2'd2, 8'd30,  16'h0000},
		'{OP_POP,    8'd5,   16'h0000, 1,  1'b0, ST_OK,    2'd0, 8'd0,   16'h0000},
		'{OP_POP,    8'd10,  16'h0000, 1,  1'b0, ST_OK,    2'd0, 8'd0,   16'h0000},
		'{OP_POP,    8'd0,   16'hFFFF, 1,  1'b0, ST_OK,    2'd0, 8'd0,   16'h0000},
		'{OP_POP,    8'd10,  16'h0000, 1,  1'b1, ST_EMPTY, 2'd0, 8'd0,   16'h0000},
		'{OP_POP,    8'd20,  16'h0000, 1,  1'b0, ST_OK,    2'd0, 8'd0,   16'h0000},
		'{OP_INSERT, 8'd25,  16'h0F0F, 15, 1'b1, ST_OK,    2'd2, 8'd25,  16'h0000},
		'{OP_INSERT, 8'd21,  16'hF0F0, 1,  1'b1, ST_FULL,  2'd2, 8'd21,  16'h0000},
		'{OP_POP,    8'd21,  16'h0000, 1,  1'b0, ST_OK,    2'd0, 8'd0,   16'h0000},
		'{OP_INSERT, 8'd22,  16'h8000, 1,  1'b1, ST_OK,    2'd2, 8'd22,  16'h0000},
		'{OP_POP,    8'd30,  16'h0000, 16, 1'b0, ST_OK,    2'd0, 8'd0,   16'h0000},
		'{OP_POP,    8'd26,  16'h0000, 1,  1'b1, ST_EMPTY, 2'd2, 8'd0,   16'h0000},
		'{OP_POP,    8'd11,  16'h0000, 1,  1'b0, ST_OK,    2'd0, 8'd0,   16'h0000},
		'{OP_POP,    8'd20,  16'h0000, 1,  1'b1, ST_EMPTY, 2'd1, 8'd0,   16'h0000}
	};

	always @(negedge clk) begin
		rsp_stall <= arst_n && ($urandom_range(99) < snk_idle_pct);
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: status=%0d band=%0d prio=%0d time=%0h",
					$time, rsp.status, rsp.band, rsp.out_priority, rsp.out_time);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.band !== want.band ||
					rsp.out_priority !== want.out_priority || rsp.out_time !== want.out_time) begin
					errors++;
					// fields: status/band/prio/time
					$display("%0t: mismatch: expected %0d/%0d/%0d/%0h, got %0d/%0d/%0d/%0h",
						$time, want.status, want.band, want.out_priority, want.out_time,
						rsp.status, rsp.band, rsp.out_priority, rsp.out_time);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d beats outstanding", $time, pending_rsp.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		rsp_t typed;
		req_t r;
		for (int b = 0; b < NBANDS; b++)
			shadow_count[b] = 0;
		shadow_limit[0] = RST_BAND_ZERO_LIMIT;
		shadow_limit[1] = RST_BAND_ONE_LIMIT;
		shadow_limit[2] = RST_BAND_TWO_LIMIT;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 33;
		snk_idle_pct = 68;
		foreach (script[i]) begin
			r.operation = script[i].op;
			r.priority_req = script[i].prio;
			r.task_time = script[i].ctime;
			typed.status = script[i].st;
			typed.band = script[i].bd;
			typed.out_priority = script[i].oprio;
			typed.out_time = script[i].otime;
			repeat (script[i].reps) send_req(r, script[i].typed, typed);
		end
		run_random(235);
		load_limits(8'd0, 8'd0, 8'd0);
		run_random(235);

		src_idle_pct = 68;
		snk_idle_pct = 33;
		load_limits(8'd255, 8'd255, 8'd255);
		run_random(235);
		// limits need not rise band to band
		load_limits(8'd200, 8'd50, 8'd255);
		run_random(235);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		load_limits(8'd63, 8'd127, 8'd255);
		run_random(235);
		load_limits(8'd0, 8'd128, 8'd255);
		run_random(235);

		drain_results();
		repeat (4) @(negedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
